### rtl/core/dmwtc_pkg.sv
// dmwtc_pkg: shared types, command codes and default sizes for the
// direct-mapped write-through data cache; no dependencies
package dmwtc_pkg;

    localparam int ADDR_W  = 16;
    localparam int WADDR_W = ADDR_W - 2;
    localparam int DATA_W  = 32;
    localparam int CMD_W   = 2;

    // default geometry, all powers of two
    localparam int LINE_COUNT_DEF     = 64;
    localparam int WORDS_PER_LINE_DEF = 4;
    localparam int MEMORY_WORDS_DEF   = 16384;

    // command codes
    localparam logic [CMD_W-1:0] CMD_READ    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PRELOAD = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] write_data;
    } t_req;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              hit;
        logic [DATA_W-1:0] read_count;
        logic [DATA_W-1:0] read_hit_count;
        logic [DATA_W-1:0] write_count;
        logic [DATA_W-1:0] write_hit_count;
    } t_rsp;

    // backing store port control
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_store_ctl;

endpackage

### rtl/core/dmwtc_store.sv
// dmwtc_store: line-wide backing store, one row per cache line worth of words
// per-word write enables; depends on dmwtc_pkg
module dmwtc_store
    import dmwtc_pkg::*;
#(
    parameter int WORDS_PER_LINE = WORDS_PER_LINE_DEF,
    parameter int MEMORY_WORDS   = MEMORY_WORDS_DEF,
    localparam int ROWS  = MEMORY_WORDS / WORDS_PER_LINE,
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1
) (
    input  logic                                   i_clk,
    input  t_store_ctl                             i_ctl,
    input  logic [ROW_W-1:0]                       i_row,
    input  logic [WORDS_PER_LINE-1:0]              i_wmask,
    input  logic [WORDS_PER_LINE-1:0][DATA_W-1:0]  i_wdata,
    output logic [WORDS_PER_LINE-1:0][DATA_W-1:0]  o_rdata
);

    logic [WORDS_PER_LINE-1:0][DATA_W-1:0] r_mem [ROWS];
    logic [WORDS_PER_LINE-1:0][DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            for (int k = 0; k < WORDS_PER_LINE; k++) begin
                if (i_wmask[k]) begin
                    r_mem[i_row][k] <= i_wdata[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rdata <= r_mem[i_row];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/direct_mapped_write_through_dcache.sv
// direct_mapped_write_through_dcache: top level of the write-through,
// write-allocate data cache with its own backing store
// depends on dmwtc_pkg and dmwtc_store
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+-------------------
//  in      | to block  | i_in_valid / o_in_ready  | i_in_data  (t_req)
//  out     | from block| o_out_valid / i_out_ready| o_out_data (t_rsp)
//
// tag, line and store rows are read in synchronous memories at the accept
// edge, then hit check, fill, update and write-through happen in the lookup
// cycle; no new transaction is taken until the lookup finishes; the result
// sits in an output register; a new transaction is taken while it waits,
// and the lookup cycle stalls only while the previous result is unread
// synchronous active-low reset clears state, valid bits and counters; tag,
// line and store memories are not cleared
// geometry parameters must be powers of two
module direct_mapped_write_through_dcache
    import dmwtc_pkg::*;
#(
    parameter int LINE_COUNT     = LINE_COUNT_DEF,
    parameter int WORDS_PER_LINE = WORDS_PER_LINE_DEF,
    parameter int MEMORY_WORDS   = MEMORY_WORDS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_req i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_rsp o_out_data
);

    localparam int WB     = $clog2(WORDS_PER_LINE);
    localparam int LB     = $clog2(LINE_COUNT);
    localparam int WIDX_W = (WB > 0) ? WB : 1;
    localparam int LINE_W = LB;
    localparam int TAG_W  = (WADDR_W - WB - LB > 0) ? (WADDR_W - WB - LB) : 1;
    localparam int ROWS   = MEMORY_WORDS / WORDS_PER_LINE;
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;

    typedef enum logic {
        S_IDLE,
        S_LOOK
    } t_state;

    // fsm, outputs and counters
    t_state             r_state;
    logic               r_out_valid;
    t_rsp               r_out;
    logic [DATA_W-1:0]  r_rd_cnt, r_rd_hit_cnt, r_wr_cnt, r_wr_hit_cnt;
    logic [DATA_W-1:0]  n_rd_cnt, n_rd_hit_cnt, n_wr_cnt, n_wr_hit_cnt;
    logic [LINE_COUNT-1:0] r_vbits;

    // captured transaction
    logic [CMD_W-1:0]   r_cmd;
    logic [WIDX_W-1:0]  r_word;
    logic [LINE_W-1:0]  r_line;
    logic [TAG_W-1:0]   r_tag;
    logic [ROW_W-1:0]   r_srow;
    logic [DATA_W-1:0]  r_wdata;

    // tag and line memories
    logic [TAG_W-1:0]                      r_tag_mem [LINE_COUNT];
    logic [WORDS_PER_LINE-1:0][DATA_W-1:0] r_line_mem [LINE_COUNT];
    logic [TAG_W-1:0]                      r_tag_q;
    logic [WORDS_PER_LINE-1:0][DATA_W-1:0] r_line_q;

    // address split of the incoming transaction
    logic [WADDR_W-1:0] w_waddr;
    logic [WIDX_W-1:0]  w_word;
    logic [LINE_W-1:0]  w_line;
    logic [TAG_W-1:0]   w_tag;
    logic [ROW_W-1:0]   w_srow;
    logic               w_accept;

    // lookup cycle
    logic                                  w_is_cache;
    logic                                  w_hit;
    logic                                  w_fin;
    logic [WORDS_PER_LINE-1:0][DATA_W-1:0] w_fill;
    logic [WORDS_PER_LINE-1:0][DATA_W-1:0] w_new;
    logic [WORDS_PER_LINE-1:0][DATA_W-1:0] w_store_q;
    logic [WORDS_PER_LINE-1:0][DATA_W-1:0] w_store_wdata;
    logic [WORDS_PER_LINE-1:0]             w_store_wmask;
    logic [WORDS_PER_LINE-1:0]             w_word_sel;
    t_store_ctl                            w_store_ctl;
    logic [ROW_W-1:0]                      w_store_row;
    logic [DATA_W-1:0]                     w_rdata;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_waddr = i_in_data.address[ADDR_W-1:2];
    assign w_word  = WIDX_W'(w_waddr % WORDS_PER_LINE);
    assign w_line  = LINE_W'((w_waddr / WORDS_PER_LINE) % LINE_COUNT);
    assign w_tag   = TAG_W'(w_waddr / (WORDS_PER_LINE * LINE_COUNT));
    // row address wraps with the store size
    assign w_srow  = ROW_W'(w_waddr / WORDS_PER_LINE);

    // capture the transaction
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd   <= i_in_data.command;
            r_word  <= w_word;
            r_line  <= w_line;
            r_tag   <= w_tag;
            r_srow  <= w_srow;
            r_wdata <= i_in_data.write_data;
        end
    end

    // hit check and line merge
    assign w_is_cache = (r_cmd == CMD_READ) || (r_cmd == CMD_WRITE);
    assign w_hit      = w_is_cache && r_vbits[r_line] && (r_tag_q == r_tag);
    assign w_fin      = (r_state == S_LOOK) && (!r_out_valid || i_out_ready);
    assign w_fill     = w_hit ? r_line_q : w_store_q;

    always_comb begin
        for (int k = 0; k < WORDS_PER_LINE; k++) begin
            w_word_sel[k] = (r_word == WIDX_W'(k));
        end
    end

    always_comb begin
        w_new = w_fill;
        if (r_cmd == CMD_WRITE) begin
            w_new[r_word] = r_wdata;
        end
    end

    assign w_rdata = (r_cmd == CMD_READ) ? w_fill[r_word] : '0;

    // store port: row read at accept, write-through or preload at finish
    always_comb begin
        w_store_ctl.rd_en = w_accept;
        w_store_ctl.wr_en = w_fin && ((r_cmd == CMD_WRITE) || (r_cmd == CMD_PRELOAD));
        w_store_row       = w_accept ? w_srow : r_srow;
        if (r_cmd == CMD_WRITE) begin
            // whole line goes back to the store
            w_store_wmask = '1;
            w_store_wdata = w_new;
        end else begin
            // preload touches one word only
            w_store_wmask = w_word_sel;
            w_store_wdata = {WORDS_PER_LINE{r_wdata}};
        end
    end

    dmwtc_store #(
        .WORDS_PER_LINE (WORDS_PER_LINE),
        .MEMORY_WORDS   (MEMORY_WORDS)
    ) u_store (
        .i_clk   (i_clk),
        .i_ctl   (w_store_ctl),
        .i_row   (w_store_row),
        .i_wmask (w_store_wmask),
        .i_wdata (w_store_wdata),
        .o_rdata (w_store_q)
    );

    // tag memory
    always_ff @(posedge i_clk) begin
        if (w_fin && w_is_cache) begin
            r_tag_mem[r_line] <= r_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_tag_q <= r_tag_mem[w_line];
        end
    end

    // line data memory, row wide
    always_ff @(posedge i_clk) begin
        if (w_fin && w_is_cache) begin
            r_line_mem[r_line] <= w_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_line_q <= r_line_mem[w_line];
        end
    end

    // counter update for the finishing transaction
    always_comb begin
        n_rd_cnt     = r_rd_cnt;
        n_rd_hit_cnt = r_rd_hit_cnt;
        n_wr_cnt     = r_wr_cnt;
        n_wr_hit_cnt = r_wr_hit_cnt;
        if (r_cmd == CMD_READ) begin
            n_rd_cnt     = r_rd_cnt + 1'b1;
            n_rd_hit_cnt = r_rd_hit_cnt + DATA_W'(w_hit);
        end else if (r_cmd == CMD_WRITE) begin
            n_wr_cnt     = r_wr_cnt + 1'b1;
            n_wr_hit_cnt = r_wr_hit_cnt + DATA_W'(w_hit);
        end
    end

    // state, valid bits, counters and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_vbits      <= '0;
            r_rd_cnt     <= '0;
            r_rd_hit_cnt <= '0;
            r_wr_cnt     <= '0;
            r_wr_hit_cnt <= '0;
        end else begin
            // a finishing transaction refills the output register
            if (w_fin) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    if (w_fin) begin
                        r_state       <= S_IDLE;
                        r_rd_cnt      <= n_rd_cnt;
                        r_rd_hit_cnt  <= n_rd_hit_cnt;
                        r_wr_cnt      <= n_wr_cnt;
                        r_wr_hit_cnt  <= n_wr_hit_cnt;
                        r_out.read_data       <= w_rdata;
                        r_out.hit             <= w_hit;
                        r_out.read_count      <= n_rd_cnt;
                        r_out.read_hit_count  <= n_rd_hit_cnt;
                        r_out.write_count     <= n_wr_cnt;
                        r_out.write_hit_count <= n_wr_hit_cnt;
                        if (w_is_cache) begin
                            r_vbits[r_line] <= 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // a result appears only at the end of a lookup cycle
    a_out_from_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_LOOK))
        else $error("result produced outside lookup");

    // an accepted transaction always moves to lookup
    a_accept_to_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_LOOK))
        else $error("accepted transaction did not enter lookup");

    // a read hit count step comes only with a read count step and a hit
    a_rd_hit_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rd_hit_cnt != $past(r_rd_hit_cnt)) |->
            ((r_rd_cnt != $past(r_rd_cnt)) && r_out.hit))
        else $error("read hit counter moved without a read hit");

    // a finished cache access leaves its line valid
    a_line_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fin && w_is_cache) |=> r_vbits[$past(r_line)])
        else $error("line not valid after fill");

    // the store is written only while finishing a transaction
    a_store_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_store_ctl.wr_en |-> ((r_state == S_LOOK) && !w_accept))
        else $error("store written outside lookup");

endmodule

### dv/tb.sv
`timescale 1ns / 100ps
// tb: self-checking bench for direct_mapped_write_through_dcache
// depends on dmwtc_pkg and the cache rtl; mirrors cache lines, tags and store

module tb;
    import dmwtc_pkg::*;

    localparam int LINES       = LINE_COUNT_DEF;
    localparam int WORDS       = WORDS_PER_LINE_DEF;
    localparam int STORE_WORDS = MEMORY_WORDS_DEF;

    // the fourth command code has no package name; the cache must ignore it
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS    = 1100;
    localparam int DIRECTED_ITEMS  = 23;
    localparam int CYCLE_LIMIT     = 600000;
    localparam int HOLD_OFF_AT     = 400;
    localparam int HOLD_OFF_CYCLES = 250;
    localparam int MAX_REPORTS     = 10;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic o_in_ready;
    t_req i_in_data   = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_rsp o_out_data;

    direct_mapped_write_through_dcache i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #6 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // cache mirror: valid bits, tags, line words, store, access and hit counters
    // ------------------------------------------------------------------
    bit              mirror_valid [LINES];
    int              mirror_tag   [LINES];
    bit [DATA_W-1:0] mirror_line  [LINES*WORDS];
    bit [DATA_W-1:0] mirror_store [STORE_WORDS];
    bit [DATA_W-1:0] reads_total  = '0;
    bit [DATA_W-1:0] reads_hit    = '0;
    bit [DATA_W-1:0] writes_total = '0;
    bit [DATA_W-1:0] writes_hit   = '0;

    // applies one transaction to the mirror and returns the response it owes
    function automatic t_rsp cache_predict(t_req req);
        int   waddr;
        int   word;
        int   line;
        int   tag;
        int   base;
        bit   hit;
        t_rsp rsp;
        waddr = int'(req.address) >> 2;
        word  = waddr % WORDS;
        line  = (waddr / WORDS) % LINES;
        tag   = waddr / (WORDS * LINES);
        base  = waddr - word;
        hit   = 1'b0;
        rsp   = '0;
        if (req.command == CMD_READ || req.command == CMD_WRITE) begin
            hit = mirror_valid[line] && (mirror_tag[line] == tag);
            // miss on read or write: allocate the whole line from the store
            if (!hit) begin
                for (int k = 0; k < WORDS; k++)
                    mirror_line[line*WORDS + k] = mirror_store[(base + k) % STORE_WORDS];
                mirror_valid[line] = 1'b1;
                mirror_tag[line]   = tag;
            end
            if (req.command == CMD_READ) begin
                reads_total++;
                if (hit)
                    reads_hit++;
                rsp.read_data = mirror_line[line*WORDS + word];
            end else begin
                writes_total++;
                if (hit)
                    writes_hit++;
                mirror_line[line*WORDS + word] = req.write_data;
                // write-through of the full line
                for (int k = 0; k < WORDS; k++)
                    mirror_store[(base + k) % STORE_WORDS] = mirror_line[line*WORDS + k];
            end
        end else if (req.command == CMD_PRELOAD) begin
            mirror_store[waddr % STORE_WORDS] = req.write_data;
        end
        rsp.hit             = hit;
        rsp.read_count      = reads_total;
        rsp.read_hit_count  = reads_hit;
        rsp.write_count     = writes_total;
        rsp.write_hit_count = writes_hit;
        return rsp;
    endfunction

    // ------------------------------------------------------------------
    // stimulus queue; tracks which store words hold data so that a line
    // fill never reads a store word that was never written
    // ------------------------------------------------------------------
    t_req pending_q      [$];
    t_rsp expected_rsp_q [$];
    bit   store_word_set [STORE_WORDS];
    int   queued_items   = 0;
    int   accepted_items = 0;
    int   results_seen   = 0;
    int   mismatch_count = 0;
    int   cycle_count    = 0;

    task automatic queue_item(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] addr,
                              logic [DATA_W-1:0] data);
        t_req req;
        int   waddr;
        req.command    = cmd;
        req.address    = addr;
        req.write_data = data;
        waddr          = int'(addr) >> 2;
        pending_q.push_back(req);
        queued_items++;
        if (cmd == CMD_PRELOAD) begin
            store_word_set[waddr % STORE_WORDS] = 1'b1;
        end else if (cmd == CMD_WRITE) begin
            for (int k = 0; k < WORDS; k++)
                store_word_set[(waddr - waddr % WORDS + k) % STORE_WORDS] = 1'b1;
        end
    endtask

    function automatic logic [DATA_W-1:0] random_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    // mostly a few tags on a few lines so that hits and conflict misses mix
    function automatic logic [ADDR_W-1:0] pick_address();
        logic [ADDR_W-1:0] a;
        a = ADDR_W'($urandom);
        if ($urandom_range(0, 9) < 7) begin
            a[15:10] = 6'($urandom_range(0, 3));
            a[9:4]   = 6'($urandom_range(0, 7));
        end
        return a;
    endfunction

    // preloads up to limit of the still unwritten words of addr's block
    task automatic preload_block(logic [ADDR_W-1:0] addr, int limit);
        int                base;
        logic [ADDR_W-1:0] a;
        base = (int'(addr) >> 2) & ~(WORDS - 1);
        for (int k = 0; k < WORDS; k++) begin
            if (!store_word_set[base + k] && limit > 0) begin
                a      = ADDR_W'((base + k) << 2);
                a[1:0] = 2'($urandom_range(0, 3));
                queue_item(CMD_PRELOAD, a, random_word());
                limit--;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // sender: bursts of random length separated by random gaps
    // ------------------------------------------------------------------
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                expected_rsp_q.push_back(cache_predict(i_in_data));
                accepted_items <= accepted_items + 1;
            end
            // payload only moves once the current transaction is taken
            if (!i_in_valid || o_in_ready) begin
                if (gap_left != 0) begin
                    gap_left   <= gap_left - 1;
                    i_in_valid <= 1'b0;
                end else if (pending_q.size() != 0) begin
                    i_in_data  <= pending_q.pop_front();
                    i_in_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: rotating ready pattern, one long hold-off to back up the cache
    // ------------------------------------------------------------------
    int          hold_left     = 0;
    bit          hold_done     = 1'b0;
    logic [15:0] ready_pattern = '1;
    int          pattern_left  = 0;

    always @(posedge i_clk) begin : receiver
        logic [15:0] next_pattern;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (!hold_done && accepted_items >= HOLD_OFF_AT) begin
            hold_done   <= 1'b1;
            hold_left   <= HOLD_OFF_CYCLES;
            i_out_ready <= 1'b0;
        end else if (pattern_left == 0) begin
            case ($urandom_range(0, 3))
                0: next_pattern = '1;
                1: next_pattern = 16'($urandom);
                2: next_pattern = 16'($urandom | $urandom);
                default: next_pattern = 16'($urandom & $urandom);
            endcase
            ready_pattern <= next_pattern;
            pattern_left  <= $urandom_range(16, 96);
            i_out_ready   <= next_pattern[0];
        end else begin
            ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
            pattern_left  <= pattern_left - 1;
            i_out_ready   <= ready_pattern[1];
        end
    end

    // ------------------------------------------------------------------
    // response checking against the oldest expectation
    // ------------------------------------------------------------------
    task automatic note_mismatch(string what, logic [DATA_W-1:0] exp_val,
                                 logic [DATA_W-1:0] act_val);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t response %0d %s: expected %h got %h",
                     $realtime, results_seen, what, exp_val, act_val);
    endtask

    task automatic check_field(string what, logic [DATA_W-1:0] exp_val,
                               logic [DATA_W-1:0] act_val);
        if (act_val !== exp_val)
            note_mismatch(what, exp_val, act_val);
    endtask

    always @(posedge i_clk) begin : response_monitor
        t_rsp want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen <= results_seen + 1;
            if (expected_rsp_q.size() == 0) begin
                note_mismatch("unexpected transaction", '0, o_out_data.read_data);
            end else begin
                want = expected_rsp_q.pop_front();
                check_field("read_data", want.read_data, o_out_data.read_data);
                check_field("hit", {31'b0, want.hit}, {31'b0, o_out_data.hit});
                check_field("read_count", want.read_count, o_out_data.read_count);
                check_field("read_hit_count", want.read_hit_count, o_out_data.read_hit_count);
                check_field("write_count", want.write_count, o_out_data.write_count);
                check_field("write_hit_count", want.write_hit_count,
                            o_out_data.write_hit_count);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus, reset and end of run
    // ------------------------------------------------------------------
    initial begin
        logic [ADDR_W-1:0] addr;
        int                roll;

        // block 0 in the store, both data extremes among its words
        queue_item(CMD_PRELOAD, 16'h0000, 32'h0000_0000);
        queue_item(CMD_PRELOAD, 16'h0004, 32'hFFFF_FFFF);
        queue_item(CMD_PRELOAD, 16'h0008, 32'hA5A5_A5A5);
        queue_item(CMD_PRELOAD, 16'h000C, 32'h5A5A_5A5A);
        queue_item(CMD_READ, 16'h0000, 32'hFFFF_FFFF);    // cold miss, line fill
        queue_item(CMD_READ, 16'h000C, 32'h0000_0000);    // read hit on last word
        queue_item(CMD_READ, 16'h0007, 32'h0000_0000);    // byte offset bits ignored
        queue_item(CMD_WRITE, 16'h0004, 32'h1234_5678);   // write hit, write-through
        // top block: tag and line at their maximum
        queue_item(CMD_PRELOAD, 16'hFFF0, 32'hFFFF_FFFF);
        queue_item(CMD_PRELOAD, 16'hFFF4, 32'h8000_0001);
        queue_item(CMD_PRELOAD, 16'hFFF8, 32'h0000_0000);
        queue_item(CMD_PRELOAD, 16'hFFFC, 32'h7FFF_FFFE);
        queue_item(CMD_WRITE, 16'hFFFF, 32'h0000_0000);   // write miss, allocate first
        queue_item(CMD_READ, 16'hFFF8, 32'h0000_0000);    // hit after allocation
        // same line as block 0, other tag
        queue_item(CMD_PRELOAD, 16'hFC00, 32'hC001_D00D);
        queue_item(CMD_PRELOAD, 16'hFC04, 32'h0BAD_F00D);
        queue_item(CMD_PRELOAD, 16'hFC08, 32'h1111_1111);
        queue_item(CMD_PRELOAD, 16'hFC0C, 32'hEEEE_EEEE);
        queue_item(CMD_READ, 16'hFC04, 32'h0000_0000);    // conflict miss evicts line 0
        queue_item(CMD_READ, 16'h0004, 32'h0000_0000);    // refill sees written-through word
        queue_item(CMD_PRELOAD, 16'h0008, 32'hDEAD_BEEF); // store only, cache untouched
        queue_item(CMD_READ, 16'h0008, 32'h0000_0000);    // hit still returns cached word
        queue_item(CMD_UNUSED, 16'hFFFF, 32'hFFFF_FFFF);  // unused command does nothing

        // random part: mostly store setup followed by an access, some noise
        // and some half-finished setups
        while (queued_items < DIRECTED_ITEMS + RANDOM_ITEMS) begin
            roll = $urandom_range(0, 99);
            addr = pick_address();
            if (roll < 6) begin
                queue_item(CMD_PRELOAD, addr, random_word());
            end else if (roll < 9) begin
                queue_item(CMD_UNUSED, addr, random_word());
            end else if (roll < 12) begin
                preload_block(addr, $urandom_range(1, WORDS - 1));
            end else begin
                preload_block(addr, WORDS);
                queue_item(($urandom_range(0, 9) < 6) ? CMD_READ : CMD_WRITE, addr,
                           random_word());
            end
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // one response per transaction, then idle cycles to catch strays
        while (results_seen != queued_items)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (mismatch_count == 0 && expected_rsp_q.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

### direct_mapped_write_through_dcache.f
rtl/core/dmwtc_pkg.sv
rtl/core/dmwtc_store.sv
rtl/core/direct_mapped_write_through_dcache.sv
dv/tb.sv
